// ----- rtl/page_frame_allocator_refcount_unit_assert.svh -----
// Assertion helpers for the page-frame allocator. They expect clk and rst in scope.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PFA_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define PFA_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/pfa_pkg.sv -----
package pfa_pkg;

  localparam int REQ_W     = 3;
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 13;
  localparam int ST_W      = 2;
  localparam int REF_OUT_W = 32;
  // Wide enough for address plus length and for the largest window.
  localparam int WIDE_W    = 34;
  localparam int MAP_BITS  = 64;
  localparam int MAP_SH    = 6;

  typedef logic [REQ_W-1:0] req_code_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam req_code_t REQ_ALLOC_BELOW = 3'd0;
  localparam req_code_t REQ_ALLOC_RUN   = 3'd1;
  localparam req_code_t REQ_RETAIN      = 3'd2;
  localparam req_code_t REQ_RELEASE     = 3'd3;
  localparam req_code_t REQ_MARK        = 3'd4;
  localparam req_code_t REQ_RESERVE     = 3'd5;

  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_NOFIT  = 2'd2;

endpackage

// ----- rtl/pfa_req_if.sv -----
interface pfa_req_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] phys_address;
  logic [ADDR_W-1:0] byte_length;
  logic [CNT_W-1:0]  page_count;

  modport source(output valid, req_type, phys_address, byte_length, page_count,
                 input ready);
  modport sink(input valid, req_type, phys_address, byte_length, page_count,
               output ready);
endinterface

// ----- rtl/pfa_rsp_if.sv -----
interface pfa_rsp_if import pfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [ADDR_W-1:0]    page_address;
  logic [REF_OUT_W-1:0] ref_count;
  logic [CNT_W-1:0]     free_count;
  logic [CNT_W-1:0]     managed_count;

  modport source(output valid, status, page_address, ref_count, free_count,
                 managed_count, input ready);
  modport sink(input valid, status, page_address, ref_count, free_count,
               managed_count, output ready);
endinterface

// ----- rtl/pfa_ram.sv -----
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/page_frame_allocator_refcount_unit.sv -----
// Physical page-frame allocator with per-page reference counts.
// The req channel takes one request per transfer: alloc below a limit, alloc a
// contiguous run, retain, release, mark a range usable, or reserve a range.
// The rsp channel returns exactly one result per request with a status, the
// allocated address, the new reference count and the free and managed counts.
// One request is worked on at a time; req.ready is high only while idle.
// Alloc below or a run of one page searches the 64-page bitmap words in
// turn, lowest first. A longer run scans one page per cycle from the top,
// pausing to load each bitmap word, then takes each page of the run in turn.
// Range operations read and write back each page in the range; retain and
// release read and update one reference count. The bitmap memory, read and
// then written back, sets the per-page cost.
// Reset clears all control state; no clearing pass is needed, as bitmap rows
// that were never written read as reserved through per-row valid bits.
// A finished result sits in an output register; if the receiver stalls, the
// next request is still accepted and worked on, and it waits only to deliver.
`include "page_frame_allocator_refcount_unit_assert.svh"

module page_frame_allocator_refcount_unit import pfa_pkg::*; #(
  parameter int PAGES      = 4096,
  parameter int PAGE_BYTES = 4096,
  parameter int REF_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp
);

  // PAGES and PAGE_BYTES are powers of two; PAGES is a multiple of 64.
  localparam int PW    = $clog2(PAGES);
  localparam int CW    = PW + 1;
  localparam int WORDS = PAGES / MAP_BITS;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SH    = $clog2(PAGE_BYTES);
  localparam int BMW   = 2 * MAP_BITS;

  localparam logic [WIDE_W-1:0] WINDOW  = WIDE_W'(PAGES) * WIDE_W'(PAGE_BYTES);
  localparam logic [WIDE_W-1:0] PB_M1   = WIDE_W'(PAGE_BYTES - 1);
  localparam logic [WIDE_W-1:0] PAGES_W = WIDE_W'(PAGES);
  localparam logic [CW-1:0]     PAGES_C = CW'(PAGES);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RNG, S_SL_RD, S_SL_CHK, S_RN_RD, S_RN_LD, S_RN_BIT,
    S_W_RD, S_W_WR, S_RC_RD, S_RC_CHK, S_DONE
  } state_t;

  typedef enum logic [1:0] {WK_TAKE, WK_MARK, WK_RESV} walk_op_t;

  state_t                state;
  req_code_t             r_req;
  logic [ADDR_W-1:0]     r_addr;
  logic [ADDR_W-1:0]     r_len;
  logic [CNT_W-1:0]      r_cnt;
  logic [WIDE_W-1:0]     r_end;
  logic [CW-1:0]         lim;
  logic [CW-1:0]         wp;
  logic [CW-1:0]         wlast;
  walk_op_t              wop;
  logic [WW-1:0]         sw;
  logic [PW-1:0]         cp;
  logic [CW-1:0]         run;
  logic [MAP_BITS-1:0]   free_buf;
  status_t               res_status;
  logic [ADDR_W-1:0]     res_paddr;
  logic [REF_BITS-1:0]   res_refs;
  logic [CW-1:0]         free_cnt;
  logic [CW-1:0]         mgd_cnt;
  logic [WORDS-1:0]      row_valid;
  logic [WW-1:0]         bm_raddr_q;

  logic                  out_valid;
  status_t               out_status;
  logic [ADDR_W-1:0]     out_paddr;
  logic [REF_BITS-1:0]   out_refs;
  logic [CW-1:0]         out_free;
  logic [CW-1:0]         out_mgd;
  logic                  load_out;

  // Bitmap memory: one row per 64 pages, usable bits above allocated bits.
  logic                  bm_we;
  logic [WW-1:0]         bm_waddr;
  logic [BMW-1:0]        bm_wdata;
  logic [WW-1:0]         bm_raddr;
  logic [BMW-1:0]        bm_rdata;
  // Reference count memory, one entry per page.
  logic                  rc_we;
  logic [PW-1:0]         rc_waddr;
  logic [REF_BITS-1:0]   rc_wdata;
  logic [PW-1:0]         rc_raddr;
  logic [REF_BITS-1:0]   rc_rdata;

  pfa_ram #(.WIDTH(BMW), .DEPTH(WORDS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  pfa_ram #(.WIDTH(REF_BITS), .DEPTH(PAGES)) u_refs (
    .clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
    .raddr(rc_raddr), .rdata(rc_rdata)
  );

  // A row that was never written holds its reset value: nothing usable,
  // everything allocated.
  logic [MAP_BITS-1:0] eff_use;
  logic [MAP_BITS-1:0] eff_alc;
  assign eff_use = row_valid[bm_raddr_q] ? bm_rdata[BMW-1:MAP_BITS] : '0;
  assign eff_alc = row_valid[bm_raddr_q] ? bm_rdata[MAP_BITS-1:0] : '1;

  // Lowest-first search over one bitmap row, limited to pages below lim.
  logic [CW-1:0]       sl_base;
  logic [MAP_BITS-1:0] sl_mask;
  logic [MAP_BITS-1:0] sl_free;
  logic                sl_hit;
  logic [MAP_SH-1:0]   sl_bit;
  logic [PW-1:0]       sl_page;

  always_comb begin
    sl_base = CW'(sw) << MAP_SH;
    for (int b = 0; b < MAP_BITS; b++) begin
      sl_mask[b] = (sl_base + CW'(b)) < lim;
    end
    sl_free = eff_use & ~eff_alc & sl_mask;
    sl_hit  = |sl_free;
    sl_bit  = '0;
    for (int b = MAP_BITS - 1; b >= 0; b--) begin
      if (sl_free[b]) begin
        sl_bit = MAP_SH'(b);
      end
    end
    sl_page = PW'(sl_base + CW'(sl_bit));
  end

  // Bit of the page under work (walk or retain/release).
  logic [MAP_SH-1:0]   wbit;
  logic [MAP_BITS-1:0] wmask;
  logic                w_use;
  logic                w_alc;
  logic [WW-1:0]       w_word;
  logic [MAP_BITS-1:0] walk_use;
  logic [MAP_BITS-1:0] walk_alc;
  logic                rc_held;
  logic                rc_ok;

  assign wbit   = wp[MAP_SH-1:0];
  assign wmask  = MAP_BITS'(1) << wbit;
  assign w_use  = eff_use[wbit];
  assign w_alc  = eff_alc[wbit];
  assign w_word = WW'(wp >> MAP_SH);
  assign rc_held = w_use && w_alc && (rc_rdata != '0);
  assign rc_ok   = rc_held && ((r_req == REQ_RELEASE) || (rc_rdata != REF_MAX));

  always_comb begin
    walk_use = eff_use;
    walk_alc = eff_alc;
    unique case (wop)
      WK_TAKE: walk_alc = eff_alc | wmask;
      WK_MARK: begin
        if (!w_use) begin
          walk_use = eff_use | wmask;
          walk_alc = eff_alc & ~wmask;
        end
      end
      WK_RESV: begin
        if (w_use) begin
          walk_use = eff_use & ~wmask;
          walk_alc = eff_alc | wmask;
        end
      end
      default: walk_alc = eff_alc;
    endcase
  end

  // Memory port control.
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = w_word;
    bm_wdata = {walk_use, walk_alc};
    bm_raddr = w_word;
    rc_we    = 1'b0;
    rc_waddr = PW'(wp);
    rc_wdata = REF_BITS'(1);
    rc_raddr = PW'(wp);
    unique case (state)
      S_SL_RD: bm_raddr = sw;
      S_SL_CHK: begin
        if (sl_hit) begin
          bm_we    = 1'b1;
          bm_waddr = sw;
          bm_wdata = {eff_use, eff_alc | (MAP_BITS'(1) << sl_bit)};
          rc_we    = 1'b1;
          rc_waddr = sl_page;
        end else begin
          bm_raddr = sw + WW'(1);
        end
      end
      S_RN_RD: bm_raddr = WW'(cp >> MAP_SH);
      S_W_WR: begin
        bm_we = 1'b1;
        rc_we = (wop == WK_TAKE);
      end
      S_RC_CHK: begin
        if (rc_ok) begin
          rc_we    = 1'b1;
          rc_wdata = (r_req == REQ_RETAIN) ? rc_rdata + REF_BITS'(1)
                                           : rc_rdata - REF_BITS'(1);
          // Dropping the last reference frees the page.
          if (r_req == REQ_RELEASE && rc_rdata == REF_BITS'(1)) begin
            bm_we    = 1'b1;
            bm_wdata = {eff_use, eff_alc & ~wmask};
          end
        end
      end
      default: bm_we = 1'b0;
    endcase
  end

  // Request decode arithmetic.
  logic [WIDE_W-1:0] d_addr;
  logic [WIDE_W-1:0] d_lim;
  logic [WIDE_W-1:0] d_end;
  logic [WIDE_W-1:0] g_first;
  logic [WIDE_W-1:0] g_last;
  logic [WIDE_W-1:0] g_last_cap;
  logic [CW-1:0]     cnt_cw;

  assign d_addr = WIDE_W'(r_addr);
  assign d_lim  = (d_addr + PB_M1) >> SH;
  assign d_end  = d_addr + WIDE_W'(r_len);
  assign cnt_cw = CW'(r_cnt);

  always_comb begin
    if (r_req == REQ_MARK) begin
      g_first = (d_addr + PB_M1) >> SH;
      g_last  = r_end >> SH;
    end else begin
      g_first = d_addr >> SH;
      g_last  = (r_end + PB_M1) >> SH;
    end
    g_last_cap = (g_last > PAGES_W) ? PAGES_W : g_last;
  end

  // The output register takes a new result once it is empty or being drained.
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.status        = out_status;
  assign rsp.page_address  = out_paddr;
  assign rsp.ref_count     = REF_OUT_W'(out_refs);
  assign rsp.free_count    = CNT_W'(out_free);
  assign rsp.managed_count = CNT_W'(out_mgd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_cnt   <= '0;
      mgd_cnt    <= '0;
      row_valid  <= '0;
    end else begin
      bm_raddr_q <= bm_raddr;
      if (bm_we) begin
        row_valid[bm_waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_req  <= req.req_type;
            r_addr <= req.phys_address;
            r_len  <= req.byte_length;
            r_cnt  <= req.page_count;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          res_paddr <= '0;
          res_refs  <= '0;
          unique case (r_req)
            REQ_ALLOC_BELOW: begin
              if (r_addr != '0) begin
                lim        <= (d_lim > PAGES_W) ? PAGES_C : CW'(d_lim);
                sw         <= '0;
                res_status <= ST_NOFIT;
                state      <= S_SL_RD;
              end else begin
                res_status <= ST_REJECT;
                state      <= S_DONE;
              end
            end
            REQ_ALLOC_RUN: begin
              if (r_cnt != '0 && WIDE_W'(r_cnt) <= PAGES_W) begin
                res_status <= ST_NOFIT;
                if (r_cnt == CNT_W'(1)) begin
                  lim   <= PAGES_C;
                  sw    <= '0;
                  state <= S_SL_RD;
                end else begin
                  cp    <= PW'(PAGES - 1);
                  run   <= '0;
                  state <= S_RN_RD;
                end
              end else begin
                res_status <= ST_REJECT;
                state      <= S_DONE;
              end
            end
            REQ_RETAIN, REQ_RELEASE: begin
              res_status <= ST_REJECT;
              if ((d_addr & PB_M1) == '0 && d_addr < WINDOW) begin
                wp    <= CW'(d_addr >> SH);
                state <= S_RC_RD;
              end else begin
                state <= S_DONE;
              end
            end
            REQ_MARK, REQ_RESERVE: begin
              res_status <= ST_REJECT;
              if (r_len != '0 && d_addr < WINDOW) begin
                r_end <= (d_end > WINDOW) ? WINDOW : d_end;
                state <= S_RNG;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              res_status <= ST_REJECT;
              state      <= S_DONE;
            end
          endcase
        end
        S_RNG: begin
          // A range that rounds to no whole page still completes.
          res_status <= ST_DONE;
          wp    <= CW'(g_first);
          wlast <= CW'(g_last_cap);
          wop   <= (r_req == REQ_MARK) ? WK_MARK : WK_RESV;
          state <= (g_first < g_last_cap) ? S_W_RD : S_DONE;
        end
        S_SL_RD: state <= S_SL_CHK;
        S_SL_CHK: begin
          if (sl_hit) begin
            res_status <= ST_DONE;
            res_paddr  <= ADDR_W'(WIDE_W'(sl_page) << SH);
            if (free_cnt != '0) begin
              free_cnt <= free_cnt - CW'(1);
            end
            state <= S_DONE;
          end else if (sl_base + CW'(MAP_BITS) >= lim) begin
            state <= S_DONE;
          end else begin
            sw <= sw + WW'(1);
          end
        end
        S_RN_RD: state <= S_RN_LD;
        S_RN_LD: begin
          free_buf <= eff_use & ~eff_alc;
          state    <= S_RN_BIT;
        end
        S_RN_BIT: begin
          if (free_buf[cp[MAP_SH-1:0]] && (run + CW'(1) >= cnt_cw)) begin
            // Highest run found: it starts at this page.
            res_status <= ST_DONE;
            res_paddr  <= ADDR_W'(WIDE_W'(cp) << SH);
            wp    <= CW'(cp);
            wlast <= CW'(cp) + cnt_cw;
            wop   <= WK_TAKE;
            state <= S_W_RD;
          end else begin
            run <= free_buf[cp[MAP_SH-1:0]] ? run + CW'(1) : '0;
            if (cp == '0) begin
              state <= S_DONE;
            end else begin
              cp <= cp - PW'(1);
              if (cp[MAP_SH-1:0] == '0) begin
                state <= S_RN_RD;
              end
            end
          end
        end
        S_W_RD: state <= S_W_WR;
        S_W_WR: begin
          unique case (wop)
            WK_TAKE: begin
              if (free_cnt != '0) begin
                free_cnt <= free_cnt - CW'(1);
              end
            end
            WK_MARK: begin
              if (!w_use) begin
                mgd_cnt  <= mgd_cnt + CW'(1);
                free_cnt <= free_cnt + CW'(1);
              end
            end
            WK_RESV: begin
              if (w_use) begin
                if (!w_alc && free_cnt != '0) begin
                  free_cnt <= free_cnt - CW'(1);
                end
                if (mgd_cnt != '0) begin
                  mgd_cnt <= mgd_cnt - CW'(1);
                end
              end
            end
            default: mgd_cnt <= mgd_cnt;
          endcase
          wp    <= wp + CW'(1);
          state <= (wp + CW'(1) == wlast) ? S_DONE : S_W_RD;
        end
        S_RC_RD: state <= S_RC_CHK;
        S_RC_CHK: begin
          if (rc_ok) begin
            res_status <= ST_DONE;
            if (r_req == REQ_RETAIN) begin
              res_refs <= rc_rdata + REF_BITS'(1);
            end else begin
              res_refs <= rc_rdata - REF_BITS'(1);
              if (rc_rdata == REF_BITS'(1)) begin
                free_cnt <= free_cnt + CW'(1);
              end
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_status <= res_status;
            out_paddr  <= res_paddr;
            out_refs   <= res_refs;
            out_free   <= free_cnt;
            out_mgd    <= mgd_cnt;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFA_ALWAYS(a_free_le_managed, free_cnt <= mgd_cnt, "free count exceeds managed count")
  `PFA_ALWAYS(a_managed_le_pages, mgd_cnt <= PAGES_C, "managed count exceeds page total")
  `PFA_IMPLIES(a_walk_bound, state == S_W_WR, wp < wlast, "page walk ran past its end")

endmodule

// ----- test/page_frame_allocator_refcount_unit_tb.sv -----
module page_frame_allocator_refcount_unit_tb;
  import pfa_pkg::*;

  localparam int NUM_PAGES   = 4096;
  localparam int PG_BYTES    = 4096;
  localparam longint unsigned WINDOW_BYTES = 64'(NUM_PAGES) * 64'(PG_BYTES);
  localparam int RANDOM_ITEMS = 1625;
  // The slowest single request is a run of the whole window: it scans every
  // page and then takes every page.
  localparam int IDLE_LIMIT   = 100000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] page_address;
    logic [31:0] ref_count;
    logic [12:0] free_count;
    logic [12:0] managed_count;
  } outcome_t;

  // Shadow of the allocator state. Each accepted request is applied here at
  // the moment of its transfer, and the outcome queued in request order.
  class frame_scoreboard;
    bit          taken[NUM_PAGES];
    bit          usable[NUM_PAGES];
    int unsigned refs[NUM_PAGES];
    int unsigned free_total;
    int unsigned managed_total;
    outcome_t    outcomes[$];
    int          mismatches;
    int          results_seen;
    int          allocs_done;
    int          nofit_seen;
    int          rejects_seen;

    function new();
      for (int p = 0; p < NUM_PAGES; p++) begin
        taken[p] = 1'b1;
        usable[p] = 1'b0;
        refs[p] = 0;
      end
      free_total = 0;
      managed_total = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function bit is_free(int p);
      return usable[p] && !taken[p];
    endfunction

    function void claim(int p);
      taken[p] = 1'b1;
      refs[p] = 1;
      if (free_total != 0) free_total--;
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function void note_request(req_code_t kind, logic [31:0] addr, logic [31:0] len,
                               logic [12:0] cnt);
      outcome_t o;
      longint unsigned lim, stop, first, last;
      int run, pg;
      o.status = ST_REJECT;
      o.page_address = '0;
      o.ref_count = '0;
      case (kind)
        REQ_ALLOC_BELOW: begin
          if (addr != 0) begin
            lim = (64'(addr) + PG_BYTES - 1) / PG_BYTES;
            if (lim > NUM_PAGES) lim = NUM_PAGES;
            o.status = ST_NOFIT;
            for (int p = 0; p < int'(lim); p++) begin
              if (is_free(p)) begin
                claim(p);
                o.status = ST_DONE;
                o.page_address = 32'(p * PG_BYTES);
                break;
              end
            end
          end
        end
        REQ_ALLOC_RUN: begin
          if (cnt != 0 && cnt <= NUM_PAGES) begin
            o.status = ST_NOFIT;
            if (cnt == 1) begin
              for (int p = 0; p < NUM_PAGES; p++) begin
                if (is_free(p)) begin
                  claim(p);
                  o.status = ST_DONE;
                  o.page_address = 32'(p * PG_BYTES);
                  break;
                end
              end
            end else begin
              // Walk down from the top; the first run long enough wins.
              run = 0;
              for (int p = NUM_PAGES - 1; p >= 0; p--) begin
                if (!is_free(p)) begin
                  run = 0;
                  continue;
                end
                run++;
                if (run < int'(cnt)) continue;
                for (int i = 0; i < int'(cnt); i++) claim(p + i);
                o.status = ST_DONE;
                o.page_address = 32'(p * PG_BYTES);
                break;
              end
            end
          end
        end
        REQ_RETAIN, REQ_RELEASE: begin
          if (addr % PG_BYTES == 0 && 64'(addr) < WINDOW_BYTES) begin
            pg = int'(addr / PG_BYTES);
            if (usable[pg] && taken[pg] && refs[pg] != 0) begin
              if (kind == REQ_RETAIN) begin
                if (refs[pg] != 32'hFFFF_FFFF) begin
                  refs[pg]++;
                  o.ref_count = refs[pg];
                  o.status = ST_DONE;
                end
              end else begin
                refs[pg]--;
                o.ref_count = refs[pg];
                o.status = ST_DONE;
                if (refs[pg] == 0) begin
                  taken[pg] = 1'b0;
                  free_total++;
                end
              end
            end
          end
        end
        REQ_MARK, REQ_RESERVE: begin
          if (len != 0 && 64'(addr) < WINDOW_BYTES) begin
            stop = 64'(addr) + 64'(len);
            if (stop > WINDOW_BYTES) stop = WINDOW_BYTES;
            // Marking rounds inward, reserving rounds outward.
            if (kind == REQ_MARK) begin
              first = (64'(addr) + PG_BYTES - 1) / PG_BYTES;
              last = stop / PG_BYTES;
            end else begin
              first = 64'(addr) / PG_BYTES;
              last = (stop + PG_BYTES - 1) / PG_BYTES;
            end
            if (last > NUM_PAGES) last = NUM_PAGES;
            for (longint unsigned p = first; p < last; p++) begin
              if (kind == REQ_MARK) begin
                if (!usable[p]) begin
                  usable[p] = 1'b1;
                  taken[p] = 1'b0;
                  managed_total++;
                  free_total++;
                end
              end else if (usable[p]) begin
                usable[p] = 1'b0;
                if (!taken[p]) begin
                  taken[p] = 1'b1;
                  if (free_total != 0) free_total--;
                end
                if (managed_total != 0) managed_total--;
              end
            end
            o.status = ST_DONE;
          end
        end
        default: o.status = ST_REJECT;
      endcase
      o.free_count = 13'(free_total);
      o.managed_count = 13'(managed_total);
      if (o.status == ST_DONE && kind inside {REQ_ALLOC_BELOW, REQ_ALLOC_RUN})
        allocs_done++;
      if (o.status == ST_NOFIT) nofit_seen++;
      if (o.status == ST_REJECT) rejects_seen++;
      outcomes.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      results_seen++;
      if (outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: status %0d address %h", got.status, got.page_address);
        return;
      end
      want = outcomes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Result %0d differs: expected st %0d addr %h refs %0d free %0d mgd %0d",
                   results_seen, want.status, want.page_address, want.ref_count,
                   want.free_count, want.managed_count);
          $display("  got st %0d addr %h refs %0d free %0d mgd %0d",
                   got.status, got.page_address, got.ref_count, got.free_count,
                   got.managed_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pfa_req_if req_ch();
  pfa_rsp_if rsp_ch();

  page_frame_allocator_refcount_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_scoreboard sb = new();
  bit stimulus_done = 1'b0;
  // Burst mode switches off the idle draws on both sides for a stretch.
  bit burst_mode = 1'b0;
  int idle_cycles = 0;

  // Watchdog: any cycle with a transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", sb.pending());
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one request and hold it until the transfer. Valid is only lowered
  // when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_request(req_code_t kind, logic [31:0] addr, logic [31:0] len,
                              logic [12:0] cnt);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.phys_address <= addr;
    req_ch.byte_length <= len;
    req_ch.page_count <= cnt;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, addr, len, cnt);
  endtask

  // Pages in the low part of the window see most of the traffic, so that
  // retains and releases often hit pages that are actually held.
  task automatic send_random_request();
    int pick;
    logic [31:0] hot_page;
    pick = $urandom_range(0, 99);
    hot_page = 32'($urandom_range(0, 299)) * PG_BYTES;
    if (pick < 24)
      send_request(REQ_ALLOC_BELOW, 32'($urandom_range(1, 320 * PG_BYTES)), $urandom,
                   13'($urandom));
    else if (pick < 34)
      send_request(REQ_ALLOC_RUN, $urandom, $urandom,
                   ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 8)));
    else if (pick < 52)
      send_request(REQ_RETAIN, hot_page, $urandom, 13'($urandom));
    else if (pick < 74)
      send_request(REQ_RELEASE, hot_page, $urandom, 13'($urandom));
    else if (pick < 84)
      send_request(REQ_MARK, 32'($urandom_range(0, 300 * PG_BYTES)),
                   32'($urandom_range(1, 64 * PG_BYTES)), 13'($urandom));
    else if (pick < 92)
      send_request(REQ_RESERVE, 32'($urandom_range(0, 300 * PG_BYTES)),
                   32'($urandom_range(1, 16 * PG_BYTES)), 13'($urandom));
    else if (pick < 95)
      // Misaligned or out-of-window page addresses.
      send_request(req_code_t'($urandom_range(REQ_RETAIN, REQ_RELEASE)), $urandom, $urandom,
                   13'($urandom));
    else if (pick < 98)
      // Fully random request, unknown codes included; long ranges walk far.
      send_request(req_code_t'($urandom_range(0, 7)), $urandom, $urandom, 13'($urandom));
    else
      send_request(REQ_MARK, 32'($urandom_range(0, 2048 * PG_BYTES)), $urandom,
                   13'($urandom));
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_ALLOC_BELOW;
    req_ch.phys_address <= '0;
    req_ch.byte_length <= '0;
    req_ch.page_count <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Nothing is usable after reset, so the first allocation
    // must report exhaustion.
    send_request(REQ_ALLOC_BELOW, 32'h0000_4000, 32'h0, 13'h0);
    send_request(req_code_t'(6), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF);
    send_request(req_code_t'(7), 32'h0, 32'h0, 13'h0);
    send_request(REQ_ALLOC_BELOW, 32'h0, 32'h0, 13'h1);
    // Empty range and a start at the window edge are rejected.
    send_request(REQ_MARK, 32'h0000_0100, 32'h0, 13'h0);
    send_request(REQ_MARK, 32'h0100_0000, 32'h1, 13'h0);
    // Inward rounding drops the partial first page.
    send_request(REQ_MARK, 32'h0000_0800, 32'h0001_0000, 13'h0);
    // A range running past the window is clipped to it.
    send_request(REQ_MARK, 32'h00FF_F000, 32'hFFFF_FFFF, 13'h0);
    send_request(REQ_MARK, 32'h00FF_E800, 32'h0000_0400, 13'h0);
    send_request(REQ_ALLOC_RUN, 32'h0, 32'h0, 13'h0);
    send_request(REQ_ALLOC_RUN, 32'h0, 32'h0, 13'd4097);
    send_request(REQ_ALLOC_RUN, 32'h0, 32'h0, 13'h1FFF);
    send_request(REQ_ALLOC_RUN, 32'h0, 32'h0, 13'd4);
    send_request(REQ_ALLOC_RUN, 32'h0, 32'h0, 13'd1);
    send_request(REQ_ALLOC_BELOW, 32'h0000_0001, 32'h0, 13'h0);
    send_request(REQ_ALLOC_BELOW, 32'hFFFF_FFFF, 32'h0, 13'h0);
    // Page checks for retain and release.
    send_request(REQ_RETAIN, 32'h0000_1001, 32'h0, 13'h0);
    send_request(REQ_RETAIN, 32'h0100_0000, 32'h0, 13'h0);
    send_request(REQ_RETAIN, 32'h0000_1000, 32'h0, 13'h0);
    send_request(REQ_RELEASE, 32'h0000_1000, 32'h0, 13'h0);
    send_request(REQ_RELEASE, 32'h0000_1000, 32'h0, 13'h0);
    send_request(REQ_RELEASE, 32'h0000_1000, 32'h0, 13'h0);
    // Outward rounding, then a full reserve and re-mark leave stale counts
    // on formerly held pages; a retain there must be refused.
    send_request(REQ_RESERVE, 32'h0000_1800, 32'h0000_1000, 13'h0);
    send_request(REQ_RESERVE, 32'h0, 32'hFFFF_FFFF, 13'h0);
    send_request(REQ_MARK, 32'h0, 32'h0100_0000, 13'h0);
    send_request(REQ_RETAIN, 32'h0000_2000, 32'h0, 13'h0);
    send_request(REQ_ALLOC_RUN, 32'h0, 32'h0, 13'd4096);
    send_request(REQ_RESERVE, 32'h0, 32'h0100_0000, 13'h0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      // Once, hold off until the allocator has drained completely.
      if (n == RANDOM_ITEMS / 2 && sb.pending() != 0) begin
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random_request();
    end
    req_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Result side: accept with random stalls and compare each transfer.
  initial begin
    int gap;
    outcome_t got;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got.status = rsp_ch.status;
      got.page_address = rsp_ch.page_address;
      got.ref_count = rsp_ch.ref_count;
      got.free_count = rsp_ch.free_count;
      got.managed_count = rsp_ch.managed_count;
      sb.check_result(got);
    end
  end

  // End of run: drain, allow a short tail for stray results, then report.
  initial begin
    wait (stimulus_done);
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Checked %0d results: %0d allocations, %0d exhausted, %0d rejected.",
             sb.results_seen, sb.allocs_done, sb.nofit_seen, sb.rejects_seen);
    $display("Final state: %0d managed pages, %0d free.", sb.managed_total, sb.free_total);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad results, %0d missing", sb.mismatches, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pfa_pkg.sv
rtl/pfa_req_if.sv
rtl/pfa_rsp_if.sv
rtl/pfa_ram.sv
rtl/page_frame_allocator_refcount_unit.sv
test/page_frame_allocator_refcount_unit_tb.sv
